FILE: rtl/brw_pkg.sv
// ----------------------------------------------------------------------------
// brw_pkg
// Shared constants, types and the arctangent table for the waypoint
// bearing/range core.
// ----------------------------------------------------------------------------
package brw_pkg;

    // CORDIC iteration count, 8 to 24
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int TAB_IDX_W    = $clog2(TABLE_LEN);

    // Integer square root: 2*65535^2 < 2^33, so the root has 17 bits
    localparam int SQRT_BITS    = 17;

    localparam int N_STAGES     = (CORDIC_STEPS > SQRT_BITS) ? CORDIC_STEPS : SQRT_BITS;
    localparam int STEP_W       = $clog2(N_STAGES);

    // Field and datapath widths
    localparam int COORD_W      = 16;
    localparam int ANG_IN_W     = 16;
    localparam int D_W          = COORD_W + 1;      // coordinate difference
    localparam int MAG_W        = COORD_W;          // |difference| <= 65535
    localparam int SQ_W         = 2 * MAG_W;        // one square
    localparam int REM_W        = SQ_W + 2;         // sum of squares / remainder
    localparam int CAND_W       = REM_W + 2;        // square root trial value
    localparam int ROOT_W       = SQRT_BITS;
    localparam int XY_W         = 32;               // CORDIC x/y
    localparam int Z_W          = 26;               // angle, 1/65536 degree
    localparam int ATAN_W       = 22;
    localparam int HS_W         = ANG_IN_W + 1;     // heading + offset
    localparam int ROUND_SH     = 9;                // 1/65536 -> 1/128 degree
    localparam int ROUND_BIAS   = 256;
    localparam int BRG_FULL_W   = Z_W - ROUND_SH;
    localparam int BRG_W        = 16;
    localparam int TURN_W       = 18;
    localparam int DIST_W       = 17;
    localparam int XY_SCALE_SH  = 12;               // coordinates times 4096
    localparam int HALF_TURN    = 180 * 65536;
    localparam int BEARING_MAX  = 23040;

    localparam int IN_DATA_W    = 6 * COORD_W;
    localparam int OUT_FIELDS_W = TURN_W + DIST_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // atan(2^-i) in degrees times 65536
    localparam logic [ATAN_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
        22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
    };

    function automatic logic [ATAN_W-1:0] atan_q16(input logic [TAB_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        val = '0;
        if (32'(idx) < TABLE_LEN) begin
            val = ATAN_TAB[idx];
        end
        return val;
    endfunction

    // Work carried down the shared CORDIC / square root pipeline
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [REM_W-1:0]       rem;
        logic [ROOT_W-1:0]      root;
        logic signed [HS_W-1:0] hs;
        logic                   zero;
    } t_work;

endpackage

FILE: rtl/brw_front.sv
// ----------------------------------------------------------------------------
// brw_front
// Three-stage front end: coordinate differences, squares and CORDIC
// pre-rotation, then the sum of squares.
// ----------------------------------------------------------------------------
module brw_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [brw_pkg::IN_DATA_W-1:0]     i_data,
    output logic                              o_valid,
    output brw_pkg::t_work                    o_work
);

    localparam int CW = brw_pkg::COORD_W;

    logic signed [CW-1:0] sx, sy, ex, ey, hd, ofs;

    assign sx  = i_data[0*CW +: CW];
    assign sy  = i_data[1*CW +: CW];
    assign ex  = i_data[2*CW +: CW];
    assign ey  = i_data[3*CW +: CW];
    assign hd  = i_data[4*CW +: CW];
    assign ofs = i_data[5*CW +: CW];

    // ---- stage A: differences ----
    logic                               r_a_valid;
    logic signed [brw_pkg::D_W-1:0]     r_a_dx, r_a_dy, n_a_dx, n_a_dy;
    logic signed [brw_pkg::HS_W-1:0]    r_a_hs, n_a_hs;

    always_comb begin
        n_a_dx = brw_pkg::D_W'(ex) - brw_pkg::D_W'(sx);
        n_a_dy = brw_pkg::D_W'(ey) - brw_pkg::D_W'(sy);
        n_a_hs = brw_pkg::HS_W'(hd) + brw_pkg::HS_W'(ofs);
    end

    // ---- stage B: squares, left-half-plane flip ----
    logic                               r_b_valid;
    logic [brw_pkg::SQ_W-1:0]           r_b_sqx, r_b_sqy, n_b_sqx, n_b_sqy;
    logic signed [brw_pkg::XY_W-1:0]    r_b_x, r_b_y, n_b_x, n_b_y;
    logic signed [brw_pkg::Z_W-1:0]     r_b_z, n_b_z;
    logic signed [brw_pkg::HS_W-1:0]    r_b_hs;
    logic                               r_b_zero, n_b_zero;

    logic signed [brw_pkg::D_W-1:0]     fx, fy;
    logic [brw_pkg::MAG_W-1:0]          mag_x, mag_y;

    always_comb begin
        fx = r_a_dx[brw_pkg::D_W-1] ? -r_a_dx : r_a_dx;
        fy = r_a_dx[brw_pkg::D_W-1] ? -r_a_dy : r_a_dy;
        mag_x = fx[brw_pkg::MAG_W-1:0];
        mag_y = r_a_dy[brw_pkg::D_W-1] ? brw_pkg::MAG_W'(-r_a_dy)
                                       : r_a_dy[brw_pkg::MAG_W-1:0];
        n_b_sqx = mag_x * mag_x;
        n_b_sqy = mag_y * mag_y;
        n_b_x   = brw_pkg::XY_W'(fx) <<< brw_pkg::XY_SCALE_SH;
        n_b_y   = brw_pkg::XY_W'(fy) <<< brw_pkg::XY_SCALE_SH;
        if (!r_a_dx[brw_pkg::D_W-1]) begin
            n_b_z = '0;
        end else if (!r_a_dy[brw_pkg::D_W-1]) begin
            n_b_z = brw_pkg::Z_W'(brw_pkg::HALF_TURN);
        end else begin
            n_b_z = -brw_pkg::Z_W'(brw_pkg::HALF_TURN);
        end
        n_b_zero = (r_a_dx == '0) && (r_a_dy == '0);
    end

    // ---- stage C: sum of squares ----
    logic                               r_c_valid;
    brw_pkg::t_work                     r_c_work, n_c_work;

    always_comb begin
        n_c_work.x    = r_b_x;
        n_c_work.y    = r_b_y;
        n_c_work.z    = r_b_z;
        n_c_work.rem  = brw_pkg::REM_W'(r_b_sqx) + brw_pkg::REM_W'(r_b_sqy);
        n_c_work.root = '0;
        n_c_work.hs   = r_b_hs;
        n_c_work.zero = r_b_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_dx   <= n_a_dx;
            r_a_dy   <= n_a_dy;
            r_a_hs   <= n_a_hs;
            r_b_sqx  <= n_b_sqx;
            r_b_sqy  <= n_b_sqy;
            r_b_x    <= n_b_x;
            r_b_y    <= n_b_y;
            r_b_z    <= n_b_z;
            r_b_hs   <= r_a_hs;
            r_b_zero <= n_b_zero;
            r_c_work <= n_c_work;
        end
    end

    assign o_valid = r_c_valid;
    assign o_work  = r_c_work;

endmodule

FILE: rtl/brw_stage.sv
// ----------------------------------------------------------------------------
// brw_stage
// One pipeline stage: a CORDIC vectoring micro-rotation and one bit of
// the restoring integer square root, side by side.
// ----------------------------------------------------------------------------
module brw_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [brw_pkg::STEP_W-1:0]    i_step,
    input  logic                          i_valid,
    input  brw_pkg::t_work                i_work,
    output logic                          o_valid,
    output brw_pkg::t_work                o_work
);

    logic                             r_valid;
    brw_pkg::t_work                   r_work, n_work;

    logic signed [brw_pkg::XY_W-1:0]  xs, ys;
    logic signed [brw_pkg::Z_W-1:0]   ang;
    logic [brw_pkg::STEP_W-1:0]       sq_bit;
    logic [brw_pkg::STEP_W:0]         sh_lin, sh_sq;
    logic [brw_pkg::CAND_W-1:0]       cand, rem_ext;

    always_comb begin
        xs  = i_work.x >>> i_step;
        ys  = i_work.y >>> i_step;
        ang = brw_pkg::Z_W'(brw_pkg::atan_q16(brw_pkg::TAB_IDX_W'(i_step)));

        // root bit handled here, from the top bit down
        sq_bit  = brw_pkg::STEP_W'(brw_pkg::SQRT_BITS - 1) - i_step;
        sh_lin  = {1'b0, sq_bit} + 1'b1;
        sh_sq   = {sq_bit, 1'b0};
        // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
        cand    = (brw_pkg::CAND_W'(i_work.root) << sh_lin)
                + (brw_pkg::CAND_W'(1) << sh_sq);
        rem_ext = brw_pkg::CAND_W'(i_work.rem);

        n_work = i_work;
        if (32'(i_step) < brw_pkg::CORDIC_STEPS) begin
            if (!i_work.y[brw_pkg::XY_W-1]) begin
                n_work.x = i_work.x + ys;
                n_work.y = i_work.y - xs;
                n_work.z = i_work.z + ang;
            end else begin
                n_work.x = i_work.x - ys;
                n_work.y = i_work.y + xs;
                n_work.z = i_work.z - ang;
            end
        end
        if (32'(i_step) < brw_pkg::SQRT_BITS && rem_ext >= cand) begin
            n_work.rem  = brw_pkg::REM_W'(rem_ext - cand);
            n_work.root = i_work.root | (brw_pkg::ROOT_W'(1) << sq_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

FILE: rtl/brw_finish.sv
// ----------------------------------------------------------------------------
// brw_finish
// Bearing rounding and clamp, root rounding, heading subtraction, and the
// output register with a one-entry skid buffer.
// ----------------------------------------------------------------------------
module brw_finish (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  brw_pkg::t_work                    i_work,
    output logic                              o_en,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [brw_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                              o_m_tuser
);

    // ---- rounding stage ----
    logic                                 r_r_valid;
    logic signed [brw_pkg::BRG_W-1:0]     r_r_bear, n_r_bear;
    logic [brw_pkg::DIST_W-1:0]           r_r_dist, n_r_dist;
    logic signed [brw_pkg::HS_W-1:0]      r_r_hs;
    logic                                 r_r_zero;

    logic signed [brw_pkg::Z_W-1:0]        z_biased;
    logic signed [brw_pkg::BRG_FULL_W-1:0] brg_full;
    logic                                  rem_gt;

    always_comb begin
        z_biased = i_work.z + brw_pkg::Z_W'(brw_pkg::ROUND_BIAS);
        brg_full = brw_pkg::BRG_FULL_W'(z_biased >>> brw_pkg::ROUND_SH);
        if (brg_full <= -brw_pkg::BEARING_MAX || brg_full > brw_pkg::BEARING_MAX) begin
            n_r_bear = brw_pkg::BRG_W'(brw_pkg::BEARING_MAX);
        end else begin
            n_r_bear = brw_pkg::BRG_W'(brg_full);
        end
        // round half up: n - r^2 > r
        rem_gt   = i_work.rem > brw_pkg::REM_W'(i_work.root);
        n_r_dist = i_work.root + brw_pkg::DIST_W'(rem_gt);
    end

    // ---- output register and skid ----
    logic                                 r_out_valid, n_out_valid;
    logic                                 r_skid_valid, n_skid_valid;
    logic signed [brw_pkg::TURN_W-1:0]    r_out_turn, n_out_turn, r_skid_turn, n_skid_turn;
    logic [brw_pkg::DIST_W-1:0]           r_out_dist, n_out_dist, r_skid_dist, n_skid_dist;
    logic                                 r_out_zero, n_out_zero, r_skid_zero, n_skid_zero;

    logic                                 en, deliver, out_free;
    logic signed [brw_pkg::TURN_W-1:0]    res_turn;
    logic [brw_pkg::DIST_W-1:0]           res_dist;

    assign en       = !r_skid_valid;
    assign deliver  = en && r_r_valid;
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        res_turn = r_r_zero ? '0
                 : brw_pkg::TURN_W'(r_r_bear) - brw_pkg::TURN_W'(r_r_hs);
        res_dist = r_r_zero ? '0 : r_r_dist;

        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_turn   = r_out_turn;
        n_out_dist   = r_out_dist;
        n_out_zero   = r_out_zero;
        n_skid_valid = r_skid_valid;
        n_skid_turn  = r_skid_turn;
        n_skid_dist  = r_skid_dist;
        n_skid_zero  = r_skid_zero;

        if (r_skid_valid) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_turn   = r_skid_turn;
                n_out_dist   = r_skid_dist;
                n_out_zero   = r_skid_zero;
                n_skid_valid = 1'b0;
            end
        end else if (deliver) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_turn  = res_turn;
                n_out_dist  = res_dist;
                n_out_zero  = r_r_zero;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_turn  = res_turn;
                n_skid_dist  = res_dist;
                n_skid_zero  = r_r_zero;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (en) begin
                r_r_valid <= i_valid;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r_bear <= n_r_bear;
            r_r_dist <= n_r_dist;
            r_r_hs   <= i_work.hs;
            r_r_zero <= i_work.zero;
        end
        r_out_turn  <= n_out_turn;
        r_out_dist  <= n_out_dist;
        r_out_zero  <= n_out_zero;
        r_skid_turn <= n_skid_turn;
        r_skid_dist <= n_skid_dist;
        r_skid_zero <= n_skid_zero;
    end

    assign o_en       = en;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = brw_pkg::OUT_DATA_W'({r_out_dist, r_out_turn});
    assign o_m_tuser  = r_out_zero;

    // skid only ever holds a second result behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid buffer full while output register empty");

    a_no_skid_after_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |=> !r_skid_valid)
        else $error("skid filled although output register was free");

    a_bearing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_r_valid |-> (r_r_bear > -brw_pkg::BEARING_MAX && r_r_bear <= brw_pkg::BEARING_MAX))
        else $error("bearing outside half-open half-turn range");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_zero) |-> (r_out_turn == '0 && r_out_dist == '0))
        else $error("zero-length result with nonzero fields");

endmodule

FILE: rtl/bearing_and_range_to_waypoint_core.sv
// ----------------------------------------------------------------------------
// bearing_and_range_to_waypoint_core
// Turn angle and rounded distance from a start/end waypoint pair, via a
// pipelined CORDIC (vectoring) and a pipelined integer square root.
// ----------------------------------------------------------------------------
//  channel  dir  payload (low bit first)
//  s_axis   in   tdata: start_x, start_y, end_x, end_y, robot_heading,
//                heading_offset (16 bits each)
//  m_axis   out  tdata: turn_angle[17:0], distance[34:18], zero pad;
//                tuser: zero_length
//
//  One transaction per cycle sustained while m_axis is ready. Stages: 3
//  front-end stages, one stage per CORDIC step / root bit (the longer of
//  the two sets the depth), rounding, output.
//  Reset (synchronous, active low) clears all valid bits; no payload reset.
//  A stall on m_axis fills a one-entry skid; the pipeline freezes only while
//  the skid is full, so no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module bearing_and_range_to_waypoint_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // start_x, start_y, end_x, end_y, robot_heading, heading_offset
    input  logic [brw_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // turn_angle[17:0], distance[34:18], zeros above
    output logic [brw_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // zero_length
    output logic                              o_m_axis_tuser
);

    logic                en;
    logic                stg_valid [brw_pkg::N_STAGES+1];
    brw_pkg::t_work      stg_work  [brw_pkg::N_STAGES+1];

    brw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .o_valid (stg_valid[0]),
        .o_work  (stg_work[0])
    );

    for (genvar k = 0; k < brw_pkg::N_STAGES; k++) begin : g_stage
        brw_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (brw_pkg::STEP_W'(k)),
            .i_valid (stg_valid[k]),
            .i_work  (stg_work[k]),
            .o_valid (stg_valid[k+1]),
            .o_work  (stg_work[k+1])
        );
    end

    brw_finish u_finish (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (stg_valid[brw_pkg::N_STAGES]),
        .i_work     (stg_work[brw_pkg::N_STAGES]),
        .o_en       (en),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser)
    );

    assign o_s_axis_tready = en;

endmodule
